// ----- rtl/ilid_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilid_pkg
// Shared types, sizes and codes for the indexed list insert/delete core.
// ---------------------------------------------------------------------------
package ilid_pkg;

  // List sizing.
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the item channels.
  localparam int CMD_W     = 3;
  localparam int POS_W     = 10;
  localparam int WORD_W    = 32;
  localparam int STAT_W    = 2;
  localparam int LEN_OUT_W = 9;

  // Derived widths for the cell row and the read tree.
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int GRP_BITS = (IDX_W + 1) / 2;
  localparam int GRP_SIZE = 1 << GRP_BITS;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int SEL_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_READ     = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_AT   = 3'd3,
    CMD_DELETE   = 3'd4
  } cmd_t;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast control to every cell of the row.
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctrl_t;

  // Sign-extend (or truncate) a stored entry to the output word width.
  function automatic logic [WORD_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] s;
    s = signed'(v);
    return WORD_W'(s);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ilid_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilid_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface ilid_req_if import ilid_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] data_word;

  modport source (output valid, output command, output position, output data_word,
                  input ready);
  modport sink (input valid, input command, input position, input data_word,
                output ready);
endinterface

interface ilid_rsp_if import ilid_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [LEN_OUT_W-1:0]     list_length;

  modport source (output valid, output read_value, output status, output list_length,
                  input ready);
  modport sink (input valid, input read_value, input status, input list_length,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/indexed_list_insert_delete_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of signed words held in a row of shifting cells.
// ---------------------------------------------------------------------------
// Each command item is handled in order: in the cycle it is accepted the whole
// cell row shifts (insert or delete) and the first stage of the read tree
// registers one cell from every group; in the result state the group
// registers are narrowed to one word and the result item is loaded into the
// output register. Because of that two-stage read tree across all cells, the
// block takes no new item until the result of the last one is loaded; a
// stalled result holds the block in its result state and the next item out. The
// list is empty after reset; cell contents need no clearing.
module indexed_list_insert_delete_core import ilid_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  ilid_req_if.sink    req,
  ilid_rsp_if.source  rsp
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t                 state;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       len_next;
  status_t                st_q;
  logic                   rd_ok_q;
  logic [SEL_W-1:0]       sel_q;
  logic                   out_valid;
  logic [WORD_W-1:0]      out_value;
  logic [STAT_W-1:0]      out_status;
  logic [LEN_OUT_W-1:0]   out_len;

  logic                   accept;
  cmd_t                   cmd;
  logic [CMD_W-1:0]       cmd_raw;
  logic [CMP_W-1:0]       len_x;
  logic [CMP_W-1:0]       pos_x;
  logic [CMP_W-1:0]       ins_pos;
  logic                   is_full;
  logic                   do_ins;
  logic                   do_del;
  logic                   rd_ok;
  status_t                st;
  cell_ctrl_t             ctrl;
  logic [WORD_W-1:0]      rd_word;

  logic [DATA_WIDTH-1:0]  cell_val [NUM_GRP][GRP_SIZE];
  logic [DATA_WIDTH-1:0]  grp_val  [NUM_GRP];

  assign accept  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cmd_raw = req.command;
  assign cmd     = cmd_t'(cmd_raw);
  assign len_x   = CMP_W'(len);
  assign pos_x   = CMP_W'(req.position);
  assign is_full = (len == LEN_W'(CAPACITY));

  // Decode the command against the current length.
  always_comb begin
    ins_pos  = pos_x;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    rd_ok    = 1'b0;
    st       = ST_RANGE;
    len_next = len;
    case (cmd)
      CMD_READ: begin
        if (pos_x < len_x) begin
          rd_ok = 1'b1;
          st    = ST_DONE;
        end
      end
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        if (cmd == CMD_INS_HEAD) begin
          ins_pos = '0;
        end else if (cmd == CMD_INS_TAIL) begin
          ins_pos = len_x;
        end
        if (ins_pos > len_x) begin
          st = ST_RANGE;
        end else if (is_full) begin
          st = ST_FULL;
        end else begin
          st       = ST_DONE;
          do_ins   = 1'b1;
          len_next = len + LEN_W'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_x < len_x) begin
          st       = ST_DONE;
          do_del   = 1'b1;
          len_next = len - LEN_W'(1);
        end
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  // Control broadcast to the cell row.
  always_comb begin
    ctrl.ins  = accept && do_ins;
    ctrl.del  = accept && do_del;
    ctrl.pos  = do_ins ? IDX_W'(ins_pos) : IDX_W'(pos_x);
    ctrl.data = DATA_WIDTH'(req.data_word);
  end

  // Cell row with neighbor links, plus padding to fill the last group.
  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    for (genvar k = 0; k < GRP_SIZE; k++) begin : g_slot
      localparam int I = g * GRP_SIZE + k;
      if (I < CAPACITY) begin : g_cell
        localparam int L = (I == 0) ? 0 : I - 1;
        localparam int R = (I == CAPACITY - 1) ? I : I + 1;
        ilid_cell u_cell (
          .clk   (clk),
          .ctrl  (ctrl),
          .idx   (IDX_W'(I)),
          .left  (cell_val[L / GRP_SIZE][L % GRP_SIZE]),
          .right (cell_val[R / GRP_SIZE][R % GRP_SIZE]),
          .word  (cell_val[g][k])
        );
      end else begin : g_pad
        assign cell_val[g][k] = '0;
      end
    end

    ilid_grp_mux u_grp (
      .clk  (clk),
      .en   (accept),
      .sel  (req.position[GRP_BITS-1:0]),
      .vals (cell_val[g]),
      .q    (grp_val[g])
    );
  end

  // Second read stage picks the group.
  always_comb begin
    rd_word = '1;
    if (rd_ok_q && (32'(sel_q) < NUM_GRP)) begin
      rd_word = widen(grp_val[sel_q]);
    end
  end

  // Sequencer, list length and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // A result item taken while idle frees the output register.
          if (rsp.ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            len     <= len_next;
            st_q    <= st;
            rd_ok_q <= rd_ok;
            sel_q   <= SEL_W'(pos_x >> GRP_BITS);
            state   <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= rd_word;
            out_status <= st_q;
            out_len    <= LEN_OUT_W'(len);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_value;
  assign rsp.status      = out_status;
  assign rsp.list_length = out_len;

  // The length never passes the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  // A taken item is followed by its result cycle, with input closed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RESULT) && !req.ready)
    else $error("item accepted while another is in flight");

  // Reads leave the length alone.
  a_read_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_READ)) |=> (len == $past(len)))
    else $error("read changed the list length");

  // A full status is only reported on a full list.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESULT) && (st_q == ST_FULL)) |-> is_full)
    else $error("full status with room left");

  // A successful read implies the read passed the range check.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESULT) && rd_ok_q) |-> (st_q == ST_DONE))
    else $error("read result without done status");

endmodule
`default_nettype wire

// ----- rtl/ilid_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilid_cell
// One list entry. Shifts up on an insert, down on a delete, or holds.
// ---------------------------------------------------------------------------
module ilid_cell import ilid_pkg::*; (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire logic [DATA_WIDTH-1:0] left,
  input  wire logic [DATA_WIDTH-1:0] right,
  output logic      [DATA_WIDTH-1:0] word
);

  // An insert takes the new data at its position and the lower neighbor
  // above it; a delete pulls the upper neighbor from the position on.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx == ctrl.pos) begin
        word <= ctrl.data;
      end else if (idx > ctrl.pos) begin
        word <= left;
      end
    end else if (ctrl.del && (idx >= ctrl.pos)) begin
      word <= right;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ilid_grp_mux.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilid_grp_mux
// First stage of the read tree: picks one cell of a group and registers it.
// ---------------------------------------------------------------------------
module ilid_grp_mux import ilid_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [GRP_BITS-1:0]   sel,
  input  wire logic [DATA_WIDTH-1:0] vals [GRP_SIZE],
  output logic      [DATA_WIDTH-1:0] q
);

  // Capture the selected cell when a command item is taken.
  always_ff @(posedge clk) begin
    if (en) begin
      q <= vals[sel];
    end
  end

endmodule
`default_nettype wire

// ----- bench/ilid_list_checker.sv -----
// ---------------------------------------------------------------------------
// ilid_list_checker
// Watches both item channels of the indexed list core, keeps a shadow copy of
// the list, predicts every result item and compares it field by field.
// ---------------------------------------------------------------------------
module ilid_list_checker import ilid_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ilid_req_if       req,
  ilid_rsp_if       rsp,
  output int        fail_count,
  output int        results_owed,
  output int        list_size
);

  typedef struct {
    logic [WORD_W-1:0]    read_value;
    status_t              status;
    logic [LEN_OUT_W-1:0] list_length;
  } list_result_t;

  // Shadow of the list contents and its length.
  logic [DATA_WIDTH-1:0] shadow_cells [CAPACITY];
  int                    shadow_len = 0;
  list_result_t          owed_results [$];
  int                    mismatches = 0;

  assign fail_count = mismatches;

  // Insert before a position, shifting later entries up by one.
  // A position past the end is rejected before the full check.
  function automatic status_t shadow_insert(input int at, input logic [WORD_W-1:0] word);
    if (at > shadow_len) return ST_RANGE;
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (int i = shadow_len; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[at] = DATA_WIDTH'(word);
    shadow_len++;
    return ST_DONE;
  endfunction

  // Apply one command to the shadow list and return the result it must give.
  function automatic list_result_t predict_command(input logic [CMD_W-1:0] code,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] word);
    list_result_t                 res;
    logic signed [DATA_WIDTH-1:0] entry_word;
    longint                       wide;
    res.read_value = '1;
    res.status     = ST_RANGE;
    case (code)
      CMD_READ: begin
        if (pos < shadow_len) begin
          entry_word     = shadow_cells[pos];
          wide           = entry_word;
          res.read_value = wide[WORD_W-1:0];
          res.status     = ST_DONE;
        end
      end
      CMD_INS_HEAD: res.status = shadow_insert(0, word);
      CMD_INS_TAIL: res.status = shadow_insert(shadow_len, word);
      CMD_INS_AT:   res.status = shadow_insert(int'(pos), word);
      CMD_DELETE: begin
        if (pos < shadow_len) begin
          for (int i = pos; i < shadow_len - 1; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
          res.status = ST_DONE;
        end
      end
      default: ;
    endcase
    res.list_length = LEN_OUT_W'(shadow_len);
    return res;
  endfunction

  // Predict on every accepted command item, compare on every accepted result item.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      owed_results.delete();
    end else begin
      if (req.valid && req.ready)
        owed_results.push_back(predict_command(req.command, req.position, req.data_word));
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          $error("result item with none expected: read_value %0d status %0d list_length %0d",
                 rsp.read_value, rsp.status, rsp.list_length);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", $signed(want.read_value),
                   rsp.read_value);
            mismatches++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.list_length !== want.list_length) begin
            $error("list_length: expected %0d, got %0d", want.list_length, rsp.list_length);
            mismatches++;
          end
        end
      end
    end
    results_owed <= owed_results.size();
    list_size    <= shadow_len;
  end

endmodule

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Drives command items into the indexed list core with random gaps and
// result stalls, and leaves prediction and checking to the list checker.
// ---------------------------------------------------------------------------
module tb;
  import ilid_pkg::*;

  // Command codes the block does not use.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int IDLE_PERCENT   = 38;
  localparam int ITEM_TARGET    = 1550;
  localparam int QUIET_FIRST    = 700;
  localparam int QUIET_LAST     = 1000;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int POS_MAX        = (1 << POS_W) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int mismatch_total;
  int results_owed;
  int list_size;
  int items_sent    = 0;
  int results_taken = 0;
  int stuck_cycles  = 0;
  int peak_len      = 0;
  bit hold_done     = 1'b0;

  ilid_req_if req_ch ();
  ilid_rsp_if rsp_ch ();

  indexed_list_insert_delete_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ilid_list_checker list_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (mismatch_total),
    .results_owed (results_owed),
    .list_size    (list_size)
  );

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly random data words, with the extremes mixed in now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Offer one command item, with random idle cycles ahead of it outside the
  // quiet window, and hold it until the block takes it.
  task automatic send_item(input logic [CMD_W-1:0] code, input int pos,
                           input logic [WORD_W-1:0] word);
    if (items_sent < QUIET_FIRST || items_sent >= QUIET_LAST)
      while ($urandom_range(99) < IDLE_PERCENT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= code;
    req_ch.position  <= POS_W'(pos);
    req_ch.data_word <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Bursts that grow the list, shrink it, or mix every command with stray
  // positions and unused codes.
  task automatic random_bursts(input int until_items);
    int               mode;
    int               burst;
    int               pick;
    int               pos;
    logic [CMD_W-1:0] code;
    while (items_sent < until_items) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        pick = $urandom_range(99);
        pos  = $urandom_range(list_size);
        if (mode == 0) begin
          if (pick < 30) code = CMD_INS_HEAD;
          else if (pick < 60) code = CMD_INS_TAIL;
          else if (pick < 90) code = CMD_INS_AT;
          else code = CMD_READ;
        end else if (mode == 1) begin
          code = (pick < 70) ? CMD_DELETE : CMD_READ;
          pos  = (list_size > 0) ? $urandom_range(list_size - 1) : 0;
        end else begin
          if (pick < 20) code = CMD_READ;
          else if (pick < 32) code = CMD_INS_HEAD;
          else if (pick < 44) code = CMD_INS_TAIL;
          else if (pick < 62) code = CMD_INS_AT;
          else if (pick < 90) code = CMD_DELETE;
          else code = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
          if ($urandom_range(99) < 15) pos = $urandom_range(POS_MAX);
          else pos = $urandom_range(list_size + 1);
        end
        send_item(code, pos, pick_word());
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int pick;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_READ;
    req_ch.position  = '0;
    req_ch.data_word = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty list: read, delete and an insert past the end all miss.
    send_item(CMD_READ, 0, '0);
    send_item(CMD_DELETE, 0, '0);
    send_item(CMD_INS_AT, 1, 32'h1234_5678);
    // An insert at the length appends; build a short list of extreme words.
    send_item(CMD_INS_AT, 0, 32'h7FFF_FFFF);
    send_item(CMD_INS_HEAD, 0, 32'h8000_0000);
    send_item(CMD_INS_TAIL, 0, 32'hFFFF_FFFF);
    send_item(CMD_INS_TAIL, POS_MAX, 32'h0000_0000);
    send_item(CMD_INS_AT, 2, 32'h5555_5555);
    send_item(CMD_INS_AT, 5, 32'hAAAA_AAAA);
    // Read every entry and one past the end.
    for (int i = 0; i < 7; i++) send_item(CMD_READ, i, '1);
    // Largest position for read, delete and insert.
    send_item(CMD_READ, POS_MAX, '0);
    send_item(CMD_DELETE, POS_MAX, '0);
    send_item(CMD_INS_AT, POS_MAX, 32'hDEAD_BEEF);
    // Unused codes change nothing.
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) send_item(CMD_W'(c), c, '1);
    // Delete at the head, at the tail and in the middle.
    send_item(CMD_DELETE, 0, '1);
    send_item(CMD_DELETE, 4, '1);
    send_item(CMD_DELETE, 1, '1);

    random_bursts(450);

    // Fill the list to capacity from all three insert commands.
    while (list_size < CAPACITY) begin
      pick = $urandom_range(2);
      if (pick == 0) send_item(CMD_INS_HEAD, 0, pick_word());
      else if (pick == 1) send_item(CMD_INS_TAIL, 0, pick_word());
      else send_item(CMD_INS_AT, $urandom_range(list_size), pick_word());
    end
    // Full list: every insert is refused, a position past the end first as a range miss.
    send_item(CMD_INS_HEAD, 0, pick_word());
    send_item(CMD_INS_TAIL, 0, pick_word());
    send_item(CMD_INS_AT, 0, pick_word());
    send_item(CMD_INS_AT, CAPACITY, pick_word());
    send_item(CMD_INS_AT, CAPACITY + 1, pick_word());
    send_item(CMD_READ, CAPACITY - 1, '0);
    send_item(CMD_READ, CAPACITY, '0);
    send_item(CMD_DELETE, CAPACITY, '0);
    // Drain it back to empty, with reads along the way.
    while (list_size > 0) begin
      pick = $urandom_range(4);
      if (pick == 0) send_item(CMD_READ, $urandom_range(list_size - 1), '0);
      else if (pick == 1) send_item(CMD_DELETE, 0, '0);
      else if (pick == 2) send_item(CMD_DELETE, list_size - 1, '0);
      else send_item(CMD_DELETE, $urandom_range(list_size - 1), '0);
    end

    random_bursts(ITEM_TARGET);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d result items for %0d command items across all commands, %s",
             results_taken, items_sent, "unused codes and out-of-range positions.");
    $display("The list reached %0d of %0d entries, was refused further inserts, then emptied.",
             peak_len, CAPACITY);
    if (mismatch_total == 0) begin
      $display("indexed_list_insert_delete_core verification clean");
    end else begin
      $display("indexed_list_insert_delete_core verification failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off so the block backs up,
  // and a quiet window with no stalls.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      if (results_taken == HOLD_AT_RESULT && !hold_done) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= (results_taken >= QUIET_FIRST && results_taken < QUIET_LAST) ||
                        ($urandom_range(99) >= IDLE_PERCENT);
        @(posedge clk);
        if (rsp_ch.valid && rsp_ch.ready) results_taken++;
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel; also tracks
  // the longest the list got.
  always @(posedge clk) begin
    if (list_size > peak_len) peak_len <= list_size;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("indexed_list_insert_delete_core verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
